[rtl/core/bfs_pkg.sv]
// bfs_pkg: shared types and constants for the ball follow steering unit.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps

package bfs_pkg;

  localparam int RADIUS_W = 16;
  localparam int X_W      = 8;
  localparam int DRIVE_W  = 7;
  localparam int MISS_W   = 3;
  localparam int CFG_AW   = 3;

  // register map
  localparam logic REG_STOP_RADIUS = 1'b0;

  localparam logic [RADIUS_W-1:0] STOP_RADIUS_RST = 16'd40;
  localparam logic [DRIVE_W-1:0]  DRIVE_FULL      = 7'd100;
  localparam logic [DRIVE_W-1:0]  DRIVE_BASE      = 7'd40;
  localparam logic [DRIVE_W-1:0]  DRIVE_OFF       = 7'd0;
  localparam logic [MISS_W-1:0]   MISS_LIMIT      = 3'd4;

  typedef enum logic [1:0] {
    OP_BALL    = 2'd0,
    OP_EMPTY   = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ACT_STEER   = 2'd0,
    ACT_CLOSE   = 2'd1,
    ACT_LOST    = 2'd2,
    ACT_TIMEOUT = 2'd3
  } action_e;

  typedef struct packed {
    op_e                 opcode;
    logic [RADIUS_W-1:0] ball_radius;
    logic [X_W-1:0]      ball_x;
    logic                last_ball;
  } item_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] left_drive;
    logic [DRIVE_W-1:0] right_drive;
    action_e            action;
  } result_t;

endpackage

[rtl/core/bfs_steer.sv]
// bfs_steer: maps a target x position to left/right drive levels.
// Depends on bfs_pkg. Purely combinational.
`timescale 1ns / 1ps

module bfs_steer #(
  parameter int IMAGE_CENTER = 80
) (
  input  logic [bfs_pkg::X_W-1:0]     x_i,
  output logic [bfs_pkg::DRIVE_W-1:0] left_o,
  output logic [bfs_pkg::DRIVE_W-1:0] right_o
);

  // distance width covers both |C - 0| and |255 - C|
  localparam int D_W     = $clog2(IMAGE_CENTER + 256);
  // reciprocal of C, exact for every 60*d below 60*C
  localparam int SHIFT   = $clog2(60 * IMAGE_CENTER * IMAGE_CENTER);
  localparam int RECIP   = ((1 << SHIFT) + IMAGE_CENTER - 1) / IMAGE_CENTER;
  localparam int RECIP60 = 60 * RECIP;
  localparam int R_W     = $clog2(RECIP60 + 1);
  localparam int P_W     = D_W + R_W;

  localparam logic [D_W-1:0]   CENTER    = D_W'(IMAGE_CENTER);
  localparam logic [D_W+3:0]   CENTER_W  = (D_W+4)'(IMAGE_CENTER);
  localparam logic [D_W+3:0]   DEAD_MULT = (D_W+4)'(10);
  localparam logic [P_W-1:0]   RECIP_W   = P_W'(RECIP60);

  logic [D_W-1:0]                 x_ext;
  logic                           below;
  logic [D_W-1:0]                 offset;
  logic [D_W+3:0]                 offset10;
  logic                           dead;
  logic                           sat;
  logic [P_W-1:0]                 prod;
  logic [5:0]                     quo;
  logic [bfs_pkg::DRIVE_W-1:0]    level;

  assign x_ext    = D_W'(x_i);
  assign below    = x_ext < CENTER;
  assign offset   = below ? (CENTER - x_ext) : (x_ext - CENTER);
  assign offset10 = (D_W+4)'(offset) * DEAD_MULT;
  assign dead     = offset10 <= CENTER_W;
  // d >= C means 60*d/C >= 60, so the level clips to full
  assign sat      = offset >= CENTER;
  assign prod     = P_W'(offset) * RECIP_W;
  assign quo      = prod[SHIFT +: 6];
  assign level    = sat ? bfs_pkg::DRIVE_FULL
                        : bfs_pkg::DRIVE_BASE + bfs_pkg::DRIVE_W'(quo);

  always_comb begin
    if (dead) begin
      left_o  = bfs_pkg::DRIVE_FULL;
      right_o = bfs_pkg::DRIVE_FULL;
    end else if (below) begin
      left_o  = bfs_pkg::DRIVE_OFF;
      right_o = level;
    end else begin
      left_o  = level;
      right_o = bfs_pkg::DRIVE_OFF;
    end
  end

endmodule

[rtl/core/bfs_track.sv]
// bfs_track: frame tracking state (running max, held x, miss count, lock)
// and the frame decision. Depends on bfs_pkg and bfs_steer.
`timescale 1ns / 1ps

module bfs_track #(
  parameter int IMAGE_CENTER = 80
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            fire_i,
  input  bfs_pkg::item_t                  item_i,
  input  logic [bfs_pkg::RADIUS_W-1:0]    stop_radius_i,
  output logic                            res_valid_o,
  output bfs_pkg::result_t                res_o
);

  logic [bfs_pkg::RADIUS_W-1:0] best_r_q, best_r_d;
  logic [bfs_pkg::X_W-1:0]      best_x_q, best_x_d;
  logic [bfs_pkg::X_W-1:0]      held_x_q, held_x_d;
  logic                         held_v_q, held_v_d;
  logic [bfs_pkg::MISS_W-1:0]   miss_q, miss_d;
  logic                         lock_q, lock_d;

  logic                         is_ball;
  logic                         frame_end;
  logic                         upd;
  logic [bfs_pkg::RADIUS_W-1:0] cur_r;
  logic [bfs_pkg::X_W-1:0]      cur_x;
  logic                         close;
  logic                         none;
  logic                         lost;
  logic [bfs_pkg::X_W-1:0]      x_sel;
  logic [bfs_pkg::DRIVE_W-1:0]  steer_l;
  logic [bfs_pkg::DRIVE_W-1:0]  steer_r;

  assign is_ball   = item_i.opcode == bfs_pkg::OP_BALL;
  assign frame_end = (is_ball && item_i.last_ball) || item_i.opcode == bfs_pkg::OP_EMPTY;
  // first of equal radii wins: strict compare
  assign upd       = is_ball && (item_i.ball_radius > best_r_q);
  assign cur_r     = upd ? item_i.ball_radius : best_r_q;
  assign cur_x     = upd ? item_i.ball_x : best_x_q;
  assign close     = cur_r >= stop_radius_i;
  assign none      = cur_r == '0;
  assign lost      = none && (!held_v_q || miss_q > bfs_pkg::MISS_LIMIT);
  assign x_sel     = none ? held_x_q : cur_x;

  bfs_steer #(
    .IMAGE_CENTER(IMAGE_CENTER)
  ) u_steer (
    .x_i    (x_sel),
    .left_o (steer_l),
    .right_o(steer_r)
  );

  // result
  always_comb begin
    res_valid_o       = 1'b0;
    res_o.left_drive  = bfs_pkg::DRIVE_OFF;
    res_o.right_drive = bfs_pkg::DRIVE_OFF;
    res_o.action      = bfs_pkg::ACT_TIMEOUT;
    if (item_i.opcode == bfs_pkg::OP_TIMEOUT) begin
      res_valid_o = 1'b1;
    end else if (frame_end) begin
      res_valid_o = 1'b1;
      if (close) begin
        res_o.action = bfs_pkg::ACT_CLOSE;
      end else if (lost) begin
        res_o.action = bfs_pkg::ACT_LOST;
      end else if (!lock_q) begin
        res_o.action      = bfs_pkg::ACT_STEER;
        res_o.left_drive  = steer_l;
        res_o.right_drive = steer_r;
      end
    end
  end

  // next state
  always_comb begin
    best_r_d = best_r_q;
    best_x_d = best_x_q;
    held_x_d = held_x_q;
    held_v_d = held_v_q;
    miss_d   = miss_q;
    lock_d   = lock_q;
    unique case (item_i.opcode)
      bfs_pkg::OP_BALL, bfs_pkg::OP_EMPTY: begin
        if (frame_end) begin
          best_r_d = '0;
          best_x_d = '0;
          if (!close && !lost) begin
            held_x_d = x_sel;
            held_v_d = 1'b1;
            miss_d   = none ? miss_q + 1'b1 : '0;
          end
        end else begin
          best_r_d = cur_r;
          best_x_d = cur_x;
        end
      end
      bfs_pkg::OP_TIMEOUT: lock_d = 1'b1;
      bfs_pkg::OP_CLEAR:   lock_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_r_q <= '0;
      best_x_q <= '0;
      held_x_q <= '0;
      held_v_q <= 1'b0;
      miss_q   <= '0;
      lock_q   <= 1'b0;
    end else if (fire_i) begin
      best_r_q <= best_r_d;
      best_x_q <= best_x_d;
      held_x_q <= held_x_d;
      held_v_q <= held_v_d;
      miss_q   <= miss_d;
      lock_q   <= lock_d;
    end
  end

endmodule

[rtl/core/ball_follow_steering_unit.sv]
// ball_follow_steering_unit: top level with stream ports and APB register.
// Depends on bfs_pkg, bfs_track and bfs_steer.
`timescale 1ns / 1ps

// Ball follow steering unit. Ball requests (radius, x, last flag) or
// frame-control requests come in on the s_axis side; the unit keeps the
// largest ball of the frame and, at frame end or on a motors timeout, sends
// one drive request (left %, right %, action) on the m_axis side. One request
// is taken every clock cycle unless the output stalls: an input register feeds
// a single pass of decision logic whose answer lands in the output register,
// which drives m_axis_tvalid. Both registers advance together whenever the
// output register is empty or being drained; while a finished result waits,
// one more request can enter the input register, and then the input stalls
// until the result is taken. Requests that give no result (plain ball
// entries, timeout clear) take one pass through the decision stage but
// leave the output register empty. stop_radius sits at APB byte address 0
// (reset 40) and is only to be written while the stream is idle.

module ball_follow_steering_unit #(
  parameter int IMAGE_CENTER = 80
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // ball requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] ball_radius, [23:16] ball_x
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  input  logic        s_axis_tlast,   // last_ball
  // drive requests
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [6:0] left_drive, [13:7] right_drive, [15:14] 0
  output logic [1:0]  m_axis_tuser,   // [1:0] action
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bfs_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic                              in_valid_q;
  bfs_pkg::item_t                    in_q;
  bfs_pkg::item_t                    in_d;
  logic                              out_valid_q;
  bfs_pkg::result_t                  out_q;
  logic [bfs_pkg::RADIUS_W-1:0]      stop_radius_q;

  logic                              advance;
  logic                              fire;
  logic                              res_valid;
  bfs_pkg::result_t                  res;
  logic                              cfg_wr;
  logic                              reg_sel;

  // ---- APB ----
  assign pready  = 1'b1;
  assign reg_sel = paddr[2] == bfs_pkg::REG_STOP_RADIUS;
  assign cfg_wr  = psel && penable && pwrite && reg_sel;
  assign prdata  = reg_sel ? 32'(stop_radius_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_radius_q <= bfs_pkg::STOP_RADIUS_RST;
    end else if (cfg_wr) begin
      stop_radius_q <= pwdata[bfs_pkg::RADIUS_W-1:0];
    end
  end

  // ---- pipeline control ----
  // both stages move when the output slot is free or draining
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign fire          = in_valid_q && advance;

  assign in_d.opcode      = bfs_pkg::op_e'(s_axis_tuser);
  assign in_d.ball_radius = s_axis_tdata[15:0];
  assign in_d.ball_x      = s_axis_tdata[23:16];
  assign in_d.last_ball   = s_axis_tlast;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= in_d;
    end
  end

  bfs_track #(
    .IMAGE_CENTER(IMAGE_CENTER)
  ) u_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .item_i       (in_q),
    .stop_radius_i(stop_radius_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= fire && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.right_drive, out_q.left_drive};
  assign m_axis_tuser  = out_q.action;

  // ---- checks ----
  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.action != bfs_pkg::ACT_STEER |->
      out_q.left_drive == bfs_pkg::DRIVE_OFF && out_q.right_drive == bfs_pkg::DRIVE_OFF)
    else $error("stop result with nonzero drive");

  a_steer_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.action == bfs_pkg::ACT_STEER |->
      out_q.left_drive <= bfs_pkg::DRIVE_FULL && out_q.right_drive <= bfs_pkg::DRIVE_FULL &&
      (out_q.left_drive != bfs_pkg::DRIVE_OFF || out_q.right_drive != bfs_pkg::DRIVE_OFF))
    else $error("steer result out of range");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input stage empty but not ready");

  a_timeout_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_q.opcode == bfs_pkg::OP_TIMEOUT |=>
      out_valid_q && out_q.action == bfs_pkg::ACT_TIMEOUT)
    else $error("timeout request gave no timeout result");

endmodule
